>>> sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the superpixel feature distance block
// Holds the record geometry, the fixed-point constants and the lane job struct.
// ----------------------------------------------------------------------------
package sfd_pkg;
	localparam int HIST_BINS_DEF  = 16;
	localparam int VALUE_BITS_DEF = 16;
	localparam int IDX_W          = 5;
	localparam int CFG_W          = 13;
	localparam int DIST_W         = 18;
	localparam int NUM_REGS       = 2;
	localparam logic [0:0] REG_HEIGHT = 1'b0;
	localparam logic [0:0] REG_WIDTH  = 1'b1;
	localparam logic [12:0] HEIGHT_RST = 13'd480;
	localparam logic [12:0] WIDTH_RST  = 13'd640;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [7:0] COLOR_DIV = 8'd255;

	// division job handed to a lane
	typedef struct packed {
		logic [63:0] num;
		logic [31:0] den;
	} sfd_div_t;
endpackage

>>> sv/sfd_lane.sv
// ----------------------------------------------------------------------------
// sfd_lane: restoring divider lane, one quotient bit per cycle
// Divides a 48-bit numerator by a 24-bit divisor; two lanes run side by side.
// ----------------------------------------------------------------------------
module sfd_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  sfd_pkg::sfd_div_t  job,
	output logic               done,
	output logic [47:0]        quot
);
	import sfd_pkg::*;
	logic [47:0] q_q;
	logic [24:0] r_q;
	logic [23:0] d_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [24:0] trial;
	logic [24:0] sub;

	assign trial = {r_q[23:0], q_q[47]};
	assign sub   = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= job.num[47:0];
			d_q <= job.den[23:0];
			r_q <= '0;
		end else if (run_q) begin
			if (!sub[24]) begin
				r_q <= sub;
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule

>>> sv/sfd_isqrt.sv
// ----------------------------------------------------------------------------
// sfd_isqrt: bit-pair integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module sfd_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] val,
	output logic        done,
	output logic [31:0] root
);
	import sfd_pkg::*;
	logic [63:0] v_q;
	logic [33:0] rem_q;
	logic [31:0] r_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [33:0] trial;
	logic [33:0] sub;

	assign trial = {rem_q[31:0], v_q[63:62]};
	assign sub   = trial - {r_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			v_q   <= val;
			rem_q <= '0;
			r_q   <= '0;
		end else if (run_q) begin
			v_q <= {v_q[61:0], 2'b00};
			if (!sub[33]) begin
				rem_q <= sub;
				r_q   <= {r_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				r_q   <= {r_q[30:0], 1'b0};
			end
		end
	end

	assign root = r_q;
endmodule

>>> sv/superpixel_feature_distance.sv
// ----------------------------------------------------------------------------
// superpixel_feature_distance: weighted distance of two superpixel features
// Loads two records one element pair per word, then computes the distance.
// ----------------------------------------------------------------------------
// Element words are taken one per cycle while the block is not busy. The word
// at the last position starts the compute phase. The histogram totals are
// summed first. The block then works through the histogram, colour and
// coordinate pairs one at a time. Each histogram or coordinate pair goes
// through the two divider lanes, one lane per record. The colour pairs use a
// reciprocal multiply. The three square roots run one after another, and the
// ST_OUT state then forms the output. An empty histogram ends the computation
// after the summing pass. The result is shown for exactly one cycle on done,
// in the cycle in which busy falls; the receiver cannot stall it.
module superpixel_feature_distance (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [sfd_pkg::IDX_W-1:0]   element_index,
	input  logic [15:0]                 first_value,
	input  logic [15:0]                 second_value,
	output logic                        done,
	output logic [sfd_pkg::DIST_W-1:0]  distance,
	output logic                        empty_histogram,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [0:0]                  cfg_index,
	input  logic [sfd_pkg::CFG_W-1:0]   cfg_data
);
	import sfd_pkg::*;
	localparam int HIST_BINS  = HIST_BINS_DEF;
	localparam int VALUE_BITS = VALUE_BITS_DEF;
	localparam int REC_LEN = HIST_BINS + 5;
	localparam int LAST    = HIST_BINS + 4;
	localparam int AW      = $clog2(REC_LEN);
	localparam int TW      = VALUE_BITS + $clog2(HIST_BINS);
	// ceil(2^26 / 5)
	localparam logic [23:0] RECIP5 = 24'd13421773;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001, ST_SUM  = 7'b0000010, ST_DIV  = 7'b0000100,
		ST_WAIT = 7'b0001000, ST_ACC  = 7'b0010000, ST_SQRT = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [VALUE_BITS-1:0] rec_a_q [REC_LEN];
	logic [VALUE_BITS-1:0] rec_b_q [REC_LEN];
	logic [CFG_W-1:0]    height_q, width_q;
	logic [TW-1:0]       tot_a_q, tot_b_q;
	logic [AW-1:0]       ptr_q;
	logic [63:0]         sum_h_q, sum_c_q, sum_xy_q;
	logic [47:0]         qa_s1, qb_s1;
	logic [1:0]          sq_sel_q;
	logic [31:0]         root_h_q, root_c_q;
	logic [46:0]         tot_q;
	logic [DIST_W-1:0]   dist_q;
	logic                empty_q, done_q;
	logic                div_go, da, db, sq_go, sq_done;
	logic                is_col;
	sfd_div_t            job_a, job_b;
	logic [47:0]         quot_a, quot_b;
	logic [24:0]         cra, crb;
	logic [47:0]         col_a, col_b;
	logic [31:0]         root;
	logic [63:0]         sq_val;
	logic [47:0]         diff, diffc;
	logic [63:0]         sq;
	logic [23:0]         dsel;
	logic [VALUE_BITS-1:0] va, vb;
	logic [46:0]         tot;
	logic [49:0]         prod;
	logic [23:0]         scaled;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign va = rec_a_q[ptr_q];
	assign vb = rec_b_q[ptr_q];

	always_comb begin
		if (32'(ptr_q) < HIST_BINS) dsel = 24'(tot_a_q);
		else if (32'(ptr_q) < HIST_BINS + 3) dsel = 24'(COLOR_DIV);
		else if (32'(ptr_q) == HIST_BINS + 3) dsel = (height_q == '0) ? 24'd1 : 24'(height_q);
		else dsel = (width_q == '0) ? 24'd1 : 24'(width_q);
		job_a.den = 32'(dsel);
		job_b.den = (32'(ptr_q) < HIST_BINS) ? 32'(tot_b_q) : 32'(dsel);
		job_a.num = (32'(ptr_q) < HIST_BINS) ? (64'(va) << 24) : (64'(va) << 16);
		job_b.num = (32'(ptr_q) < HIST_BINS) ? (64'(vb) << 24) : (64'(vb) << 16);
	end

	// (v << 16) / 255 = v*257 + floor(v/255), floor(v/255) = ((v+1)*257) >> 16
	assign is_col = (32'(ptr_q) >= HIST_BINS) && (32'(ptr_q) < HIST_BINS + 3);
	assign cra    = (25'(va) + 25'd1) * 25'd257;
	assign crb    = (25'(vb) + 25'd1) * 25'd257;
	assign col_a  = 48'(va) * 48'd257 + 48'(cra[24:16]);
	assign col_b  = 48'(vb) * 48'd257 + 48'(crb[24:16]);

	assign div_go = (state_q == ST_DIV) && !is_col;

	sfd_lane u_lane_a (.clk, .arst_n, .go(div_go), .job(job_a), .done(da), .quot(quot_a));
	sfd_lane u_lane_b (.clk, .arst_n, .go(div_go), .job(job_b), .done(db), .quot(quot_b));

	assign diff  = (qa_s1 > qb_s1) ? qa_s1 - qb_s1 : qb_s1 - qa_s1;
	assign diffc = (32'(ptr_q) >= HIST_BINS && diff > 48'h400000) ? 48'h400000 : diff;
	assign sq    = 64'(diffc[31:0]) * 64'(diffc[31:0]);

	assign sq_val = (sq_sel_q == 2'd0) ? sum_h_q : (sq_sel_q == 2'd1) ? sum_c_q : sum_xy_q;
	sfd_isqrt u_sqrt (.clk, .arst_n, .go(sq_go), .val(sq_val), .done(sq_done), .root(root));

	assign tot    = 47'(7 * 64'(root_h_q)) + 47'(64'(root_c_q) << 9) + 47'(64'(root) << 8);
	// tot / 2560 = (tot >> 9) / 5
	assign prod   = 50'(tot_q[34:9]) * 50'(RECIP5);
	assign scaled = prod[49:26];

	always_ff @(posedge clk) begin
		if (start && !busy && 32'(element_index) <= LAST) begin
			rec_a_q[AW'(element_index)] <= first_value[VALUE_BITS-1:0];
			rec_b_q[AW'(element_index)] <= second_value[VALUE_BITS-1:0];
		end
		if (da) begin
			qa_s1 <= quot_a;
			qb_s1 <= quot_b;
		end else if (state_q == ST_DIV && is_col) begin
			qa_s1 <= col_a;
			qb_s1 <= col_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			height_q <= HEIGHT_RST;
			width_q  <= WIDTH_RST;
			tot_a_q  <= '0;
			tot_b_q  <= '0;
			ptr_q    <= '0;
			sum_h_q  <= '0;
			sum_c_q  <= '0;
			sum_xy_q <= '0;
			sq_sel_q <= '0;
			sq_go    <= 1'b0;
			root_h_q <= '0;
			root_c_q <= '0;
			tot_q    <= '0;
			dist_q   <= '0;
			empty_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			sq_go  <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_HEIGHT) height_q <= cfg_data;
				else width_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (start && 32'(element_index) == LAST) begin
						state_q <= ST_SUM;
						ptr_q   <= '0;
						tot_a_q <= '0;
						tot_b_q <= '0;
					end
				end
				ST_SUM: begin
					tot_a_q <= tot_a_q + TW'(va);
					tot_b_q <= tot_b_q + TW'(vb);
					if (32'(ptr_q) == HIST_BINS - 1) begin
						ptr_q <= '0;
						state_q <= ST_DIV;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (32'(ptr_q) == HIST_BINS - 1 &&
					    ((tot_a_q + TW'(va)) == '0 || (tot_b_q + TW'(vb)) == '0)) begin
						dist_q  <= '0;
						empty_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
					sum_h_q  <= '0;
					sum_c_q  <= '0;
					sum_xy_q <= '0;
				end
				ST_DIV: state_q <= is_col ? ST_ACC : ST_WAIT;
				ST_WAIT: if (da) state_q <= ST_ACC;
				ST_ACC: begin
					if (32'(ptr_q) < HIST_BINS) sum_h_q <= sum_h_q + sq;
					else if (32'(ptr_q) < HIST_BINS + 3) sum_c_q <= sum_c_q + sq;
					else sum_xy_q <= sum_xy_q + sq;
					if (32'(ptr_q) == LAST) begin
						sq_sel_q <= 2'd0;
						sq_go    <= 1'b1;
						state_q  <= ST_SQRT;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						if (sq_sel_q == 2'd0) root_h_q <= root;
						if (sq_sel_q == 2'd1) root_c_q <= root;
						if (sq_sel_q == 2'd2) begin
							tot_q   <= tot;
							state_q <= ST_OUT;
						end else begin
							sq_sel_q <= sq_sel_q + 2'd1;
							sq_go    <= 1'b1;
						end
					end
				end
				ST_OUT: begin
					dist_q  <= (tot_q[46:35] != '0 || scaled > 24'(DIST_MAX)) ?
						DIST_MAX : scaled[DIST_W-1:0];
					empty_q <= 1'b0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done            = done_q;
	assign distance        = dist_q;
	assign empty_histogram = empty_q;

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && empty_histogram |-> distance == '0) else $error("empty with nonzero distance");
	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		da == db) else $error("divider lanes out of step");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
endmodule
